// ----- src/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and constants for the oldest-first evicting session id cache.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int KEY_BYTES_DEF   = 32;
  localparam int HANDLE_BITS_DEF = 16;

  // fixed field widths of the request and result items
  localparam int KIND_W     = 2;
  localparam int LEN_W      = 6;
  localparam int WORD_W     = 64;
  localparam int KEY_WORDS  = 4;
  localparam int HANDLE_W   = 16;
  localparam int MAXENT_W   = 5;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

endpackage

// ----- src/sic_key_ram.sv -----
// ----------------------------------------------------------------------------
// sic_key_ram
// Key row store, one row per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
module sic_key_ram
  import sic_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int WIDTH = KEY_BYTES_DEF * 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/fifo_evicting_session_id_cache.sv -----
// ----------------------------------------------------------------------------
// fifo_evicting_session_id_cache
// Session table kept in insertion order, matched on a byte key, with
// oldest-first eviction on add.
// ----------------------------------------------------------------------------
//  channel  direction  ports                          contents
//  in       slave      in_tvalid/tready/tdata/tuser   one add, lookup or remove
//  out      master     out_tvalid/tready/tdata        one result per request
//  cfg      write      cfg_we/cfg_wdata               max_entries register
//
//  a valid request scans the whole table before its result: one entry is
//  compared per cycle through the key ram read port
//  an invalid request skips the scan and commit; in_tready is high only while idle
//  a result waits in the output register; the next item is taken meanwhile
//  reset (rst_n low, synchronous) empties the table and clears max_entries
// ----------------------------------------------------------------------------
module fifo_evicting_session_id_cache
  import sic_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_len[5:0], key_word0..3[261:6], new_handle[277:262], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], found_handle[17:2], evicted[18], evicted_handle[34:19], pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [MAXENT_W-1:0]   cfg_wdata
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = KEY_BYTES * 8;
  localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  // input unpacking
  logic [LEN_W-1:0]              in_len;
  logic [KEY_WORDS*WORD_W-1:0]   in_key_full;
  logic [HANDLE_W-1:0]           in_handle;
  logic [KW-1:0]                 in_key;
  logic                          in_bad;

  assign in_len      = in_tdata[LEN_W-1:0];
  assign in_key_full = in_tdata[LEN_W +: KEY_WORDS*WORD_W];
  assign in_handle   = in_tdata[LEN_W + KEY_WORDS*WORD_W +: HANDLE_W];

  // bytes past key_len are zeroed before storing or comparing
  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      in_key[b*8 +: 8] = (b < in_len) ? in_key_full[b*8 +: 8] : 8'h00;
    end
  end

  assign in_bad = (in_len == '0) || (in_len > KEY_BYTES) ||
                  !(in_tuser == KIND_ADD || in_tuser == KIND_LOOKUP ||
                    in_tuser == KIND_REMOVE);

  // state
  state_t              state_r, state_nxt;
  logic [MAXENT_W-1:0] max_entries_r;
  logic [CW-1:0]       count_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [IW-1:0]       rank_r [ENTRIES];
  logic [LEN_W-1:0]    len_r  [ENTRIES];
  logic [HW-1:0]       hnd_r  [ENTRIES];

  // request
  logic [KIND_W-1:0]   req_kind_r;
  logic [LEN_W-1:0]    req_len_r;
  logic [KW-1:0]       req_key_r;
  logic [HW-1:0]       req_hnd_r;

  // scan
  logic [CW-1:0]       scan_r;
  logic                chk_vld_r;
  logic [IW-1:0]       chk_idx_r;
  logic                best_fnd_r;
  logic [IW-1:0]       best_idx_r;
  logic [IW-1:0]       best_rank_r;
  logic [HW-1:0]       best_hnd_r;
  logic                free_fnd_r;
  logic [IW-1:0]       free_idx_r;

  // result
  status_t             res_status_r;
  logic [HANDLE_W-1:0] res_found_r;
  logic                res_evicted_r;
  logic [HANDLE_W-1:0] res_ev_hnd_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                accept;
  logic                issue;
  logic                scan_done;
  logic                out_free;
  logic [KW-1:0]       rd_data;
  logic [CW-1:0]       limit;
  logic                evict_due;
  logic                evict;
  logic [IW-1:0]       oldest_rank;
  logic [IW-1:0]       slot;
  logic                chk_valid;
  logic                chk_hit;
  logic                ram_we;

  assign accept    = in_tvalid && in_tready;
  assign issue     = (state_r == S_SCAN) && (scan_r < ENTRIES);
  assign scan_done = (state_r == S_SCAN) && (scan_r == ENTRIES) && chk_vld_r;
  assign out_free  = !out_valid_r || out_tready;

  // capacity limit, 0 or anything above ENTRIES selects ENTRIES
  assign limit = ((max_entries_r == '0) || (max_entries_r > ENTRIES)) ?
                 CW'(ENTRIES) : CW'(max_entries_r);
  assign evict_due   = (count_r >= limit) && (count_r != '0);
  assign oldest_rank = IW'(count_r - 1'b1);
  assign evict       = evict_due && best_fnd_r;
  // the freed slot of the evicted entry competes with the first empty one
  assign slot = (evict && !(free_fnd_r && (free_idx_r < best_idx_r))) ?
                best_idx_r : free_idx_r;

  // shared compare unit: one entry per cycle against the request
  assign chk_valid = chk_vld_r && valid_r[chk_idx_r];
  assign chk_hit   = chk_valid && (len_r[chk_idx_r] == req_len_r) &&
                     (rd_data == req_key_r);

  assign ram_we = (state_r == S_COMMIT) && (req_kind_r == KIND_ADD);

  sic_key_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (KW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data (req_key_r),
    .rd_en   (issue),
    .rd_addr (scan_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = in_bad ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= '0;
    end else if (cfg_we) begin
      max_entries_r <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r <= in_tuser;
      req_len_r  <= in_len;
      req_key_r  <= in_key;
      req_hnd_r  <= in_handle[HW-1:0];
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r  <= 1'b0;
      best_fnd_r <= 1'b0;
      free_fnd_r <= 1'b0;
      scan_r     <= '0;
    end else begin
      chk_vld_r <= issue;
      if (accept) begin
        scan_r     <= '0;
        best_fnd_r <= 1'b0;
        free_fnd_r <= 1'b0;
      end else begin
        if (issue) begin
          scan_r <= scan_r + 1'b1;
        end
        if (chk_vld_r) begin
          if (req_kind_r == KIND_ADD) begin
            if (chk_valid && (rank_r[chk_idx_r] == oldest_rank) && !best_fnd_r) begin
              best_fnd_r <= 1'b1;
            end
            if (!valid_r[chk_idx_r] && !free_fnd_r) begin
              free_fnd_r <= 1'b1;
            end
          end else if (chk_hit &&
                       (!best_fnd_r || (rank_r[chk_idx_r] < best_rank_r))) begin
            best_fnd_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx_r <= scan_r[IW-1:0];
    end
    if (chk_vld_r && !accept) begin
      if (req_kind_r == KIND_ADD) begin
        if (chk_valid && (rank_r[chk_idx_r] == oldest_rank) && !best_fnd_r) begin
          best_idx_r  <= chk_idx_r;
          best_rank_r <= rank_r[chk_idx_r];
          best_hnd_r  <= hnd_r[chk_idx_r];
        end
        if (!valid_r[chk_idx_r] && !free_fnd_r) begin
          free_idx_r <= chk_idx_r;
        end
      end else if (chk_hit &&
                   (!best_fnd_r || (rank_r[chk_idx_r] < best_rank_r))) begin
        best_idx_r  <= chk_idx_r;
        best_rank_r <= rank_r[chk_idx_r];
        best_hnd_r  <= hnd_r[chk_idx_r];
      end
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (state_r == S_COMMIT) begin
      if (req_kind_r == KIND_ADD) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j] && !(evict && (best_idx_r == IW'(j)))) begin
            rank_r[j] <= rank_r[j] + 1'b1;
          end
        end
        if (evict) begin
          valid_r[best_idx_r] <= 1'b0;
        end
        valid_r[slot] <= 1'b1;
        rank_r[slot]  <= '0;
        len_r[slot]   <= req_len_r;
        hnd_r[slot]   <= req_hnd_r;
        if (!evict) begin
          count_r <= count_r + 1'b1;
        end
      end else if ((req_kind_r == KIND_REMOVE) && best_fnd_r) begin
        // close the gap: every older entry moves one step younger
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j] && (rank_r[j] > best_rank_r)) begin
            rank_r[j] <= rank_r[j] - 1'b1;
          end
        end
        valid_r[best_idx_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (accept && in_bad) begin
      res_status_r  <= STAT_INVALID;
      res_found_r   <= '0;
      res_evicted_r <= 1'b0;
      res_ev_hnd_r  <= '0;
    end else if (state_r == S_COMMIT) begin
      res_found_r   <= '0;
      res_evicted_r <= 1'b0;
      res_ev_hnd_r  <= '0;
      if (req_kind_r == KIND_ADD) begin
        res_status_r  <= STAT_OK;
        res_evicted_r <= evict;
        if (evict) begin
          res_ev_hnd_r <= HANDLE_W'(best_hnd_r);
        end
      end else if (!best_fnd_r) begin
        res_status_r <= STAT_NOT_FOUND;
      end else begin
        res_status_r <= STAT_OK;
        if (req_kind_r == KIND_LOOKUP) begin
          res_found_r <= HANDLE_W'(best_hnd_r);
        end else begin
          res_ev_hnd_r <= HANDLE_W'(best_hnd_r);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= OUT_DATA_W'({res_ev_hnd_r, res_evicted_r, res_found_r,
                                 res_status_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == $countones(valid_r))
    else $error("entry count out of step with valid bits");

  a_add_leaves_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && req_kind_r == KIND_ADD) |=> valid_r != '0)
    else $error("table empty after an add");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && req_kind_r == KIND_REMOVE && best_fnd_r) |=>
      count_r == $past(count_r) - 1'b1)
    else $error("remove hit did not lower the count");

  a_evict_only_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && req_kind_r == KIND_ADD && evict) |-> count_r >= limit)
    else $error("eviction below the capacity limit");
`endif

endmodule
